// ===== hw/rtl/cvdg_pkg.sv =====
package cvdg_pkg;

  localparam int unsigned VISIBLE_WIDTH = 256;
  localparam int unsigned VISIBLE_LINES = 192;

  localparam logic [8:0] HPalenOn   = 9'd4;
  localparam logic [8:0] HBorderOff = 9'd8;
  localparam logic [8:0] HBorderOn  = 9'(8 + VISIBLE_WIDTH);
  localparam logic [8:0] HBlankOn   = 9'(8 + VISIBLE_WIDTH + 64);
  localparam logic [8:0] HBlankOff  = 9'(8 + VISIBLE_WIDTH + 64 + 80);
  localparam logic [8:0] HLineEnd   = 9'(8 + VISIBLE_WIDTH + 64 + 80 + 48 - 1);
  localparam logic [8:0] VBorderOn  = 9'(VISIBLE_LINES);
  localparam logic [8:0] VBlankOn   = 9'(VISIBLE_LINES + 25);
  localparam logic [8:0] VBlankOff  = 9'(VISIBLE_LINES + 25 + 9 + 3 + 8);
  localparam logic [8:0] VFieldEnd  = 9'(VISIBLE_LINES + 25 + 9 + 3 + 8 + 25);
  localparam logic [8:0] FbCols     = 9'(VISIBLE_WIDTH + 48 + 64);
  localparam logic [8:0] FbRows     = 9'(VISIBLE_LINES + 50);
  localparam logic [8:0] VTop       = 9'd25;

  localparam logic [10:0] ScreenBase  = 11'h200;
  localparam logic [7:0]  CharReset   = 8'h12;
  localparam logic [7:0]  ShiftReset  = 8'hF3;
  localparam logic [7:0]  PalReset    = 8'h0F;
  localparam logic [8:0]  ColReset    = 9'd47;
  localparam logic [3:0]  CodeFg      = 4'h8;
  localparam logic [3:0]  CodeBg      = 4'h9;

  typedef enum logic {
    FUNC_TICK      = 1'b0,
    FUNC_PAL_WRITE = 1'b1
  } func_e;

  typedef struct packed {
    logic       func;
    logic [7:0] pal_value;
    logic [7:0] rom_byte;
    logic [7:0] ram_byte;
  } in_item_t;

  typedef struct packed {
    logic        pixel_write;
    logic [8:0]  pixel_x;
    logic [8:0]  pixel_y;
    logic [23:0] pixel_rgb;
    logic [8:0]  line_number;
    logic        hblank_flag;
    logic        vblank_flag;
    logic        irq_pulse;
    logic        field_end;
    logic [10:0] rom_addr;
    logic [10:0] ram_addr;
  } result_t;

  function automatic logic [23:0] palette_rgb(input logic [3:0] idx);
    logic [23:0] rgb;
    case (idx)
      4'd0:    rgb = 24'h000000;
      4'd1:    rgb = 24'h3800ff;
      4'd2:    rgb = 24'hff00b0;
      4'd3:    rgb = 24'hff9632;
      4'd4:    rgb = 24'hffff20;
      4'd5:    rgb = 24'h47ff8b;
      4'd6:    rgb = 24'h00e0ff;
      4'd7:    rgb = 24'h6900ff;
      4'd8:    rgb = 24'h7f7f7f;
      4'd9:    rgb = 24'h64249f;
      4'd10:   rgb = 24'h9c2582;
      4'd11:   rgb = 24'hb97b62;
      4'd12:   rgb = 24'ha0d55e;
      4'd13:   rgb = 24'h67de79;
      4'd14:   rgb = 24'h00bae9;
      default: rgb = 24'hffffff;
    endcase
    return rgb;
  endfunction

endpackage

// ===== hw/rtl/cvdg_in_if.sv =====
interface cvdg_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] pal_value;
  logic [7:0] rom_byte;
  logic [7:0] ram_byte;

  modport source (output valid, func, pal_value, rom_byte, ram_byte, input ready);
  modport sink (input valid, func, pal_value, rom_byte, ram_byte, output ready);
endinterface

// ===== hw/rtl/cvdg_out_if.sv =====
interface cvdg_out_if;
  logic        valid;
  logic        ready;
  logic        pixel_write;
  logic [8:0]  pixel_x;
  logic [8:0]  pixel_y;
  logic [23:0] pixel_rgb;
  logic [8:0]  line_number;
  logic        hblank_flag;
  logic        vblank_flag;
  logic        irq_pulse;
  logic        field_end;
  logic [10:0] rom_addr;
  logic [10:0] ram_addr;

  modport source (
    output valid, pixel_write, pixel_x, pixel_y, pixel_rgb, line_number, hblank_flag,
           vblank_flag, irq_pulse, field_end, rom_addr, ram_addr,
    input  ready
  );
  modport sink (
    input  valid, pixel_write, pixel_x, pixel_y, pixel_rgb, line_number, hblank_flag,
           vblank_flag, irq_pulse, field_end, rom_addr, ram_addr,
    output ready
  );
endinterface

// ===== hw/rtl/cvdg_core.sv =====
module cvdg_core
  import cvdg_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  in_item_t item_i,
  output result_t  res_o
);

  logic [8:0] dot_q, dot_d;
  logic [8:0] line_q, line_d;
  logic       hborder_q, hborder_d;
  logic       hblank_q, hblank_d;
  logic       code_en_q, code_en_d;
  logic       vborder_q, vborder_d;
  logic       vblank_q, vblank_d;
  logic [7:0] char_q, char_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] pal_q, pal_d;
  logic [8:0] col_q, col_d;
  logic [8:0] row_q, row_d;

  logic [2:0] sub;
  logic [8:0] line_inc;
  logic       visible;
  logic [3:0] color_idx;
  logic       irq;
  logic       fend;

  always_comb begin
    dot_d     = dot_q;
    line_d    = line_q;
    hborder_d = hborder_q;
    hblank_d  = hblank_q;
    code_en_d = code_en_q;
    vborder_d = vborder_q;
    vblank_d  = vblank_q;
    char_d    = char_q;
    shift_d   = shift_q;
    pal_d     = pal_q;
    col_d     = col_q;
    row_d     = row_q;
    irq       = 1'b0;
    fend      = 1'b0;
    sub       = dot_q[2:0];
    line_inc  = line_q + 9'd1;
    visible   = !hborder_q && !vborder_q && (row_q < FbRows) && (col_q < FbCols);
    color_idx = shift_q[7] ? pal_q[3:0] : pal_q[7:4];

    res_o = '0;

    if (item_i.func == FUNC_PAL_WRITE) begin
      pal_d = item_i.pal_value;
    end else begin
      if (visible) begin
        res_o.pixel_write = 1'b1;
        res_o.pixel_x     = col_q;
        res_o.pixel_y     = VTop + row_q;
        res_o.pixel_rgb   = palette_rgb(color_idx);
      end
      col_d = col_q + 9'd1;

      shift_d = (sub == 3'd0) ? item_i.rom_byte : {shift_q[6:0], 1'b0};

      // control codes act on the character latched in the previous cell
      if (code_en_q && sub == 3'd0) begin
        if (char_q[7:4] == CodeFg) pal_d = {pal_q[7:4], char_q[3:0]};
        if (char_q[7:4] == CodeBg) pal_d = {char_q[3:0], pal_q[3:0]};
      end

      if (sub == 3'd4) char_d = item_i.ram_byte;

      if (dot_q == HPalenOn) code_en_d = 1'b1;
      if (dot_q == HBorderOff) hborder_d = 1'b0;
      if (dot_q == HBorderOn) begin
        hborder_d = 1'b1;
        code_en_d = 1'b0;
        pal_d     = PalReset;
      end
      if (dot_q == HBlankOn) hblank_d = 1'b1;
      if (dot_q == HBlankOff) begin
        hblank_d = 1'b0;
        row_d    = row_q + 9'd1;
        col_d    = '0;
      end
      if (dot_q == HLineEnd) begin
        dot_d  = '0;
        line_d = line_inc;
        if (line_inc == VBorderOn) vborder_d = 1'b1;
        if (line_inc == VBlankOn) begin
          vblank_d = 1'b1;
          irq      = 1'b1;
        end
        if (line_inc == VBlankOff) vblank_d = 1'b0;
        if (line_inc == VFieldEnd) begin
          line_d    = '0;
          vborder_d = 1'b0;
          row_d     = '0;
          fend      = 1'b1;
        end
      end else begin
        dot_d = dot_q + 9'd1;
      end
    end

    res_o.line_number = line_d;
    res_o.hblank_flag = hblank_d;
    res_o.vblank_flag = vblank_d;
    res_o.irq_pulse   = irq;
    res_o.field_end   = fend;
    res_o.rom_addr    = {char_d, line_d[2:0]};
    res_o.ram_addr    = ScreenBase + {1'b0, line_d[7:3], dot_d[7:3]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q     <= '0;
      line_q    <= '0;
      hborder_q <= 1'b1;
      hblank_q  <= 1'b0;
      code_en_q <= 1'b0;
      vborder_q <= 1'b0;
      vblank_q  <= 1'b0;
      char_q    <= CharReset;
      shift_q   <= ShiftReset;
      pal_q     <= PalReset;
      col_q     <= ColReset;
      row_q     <= '0;
    end else if (step_i) begin
      dot_q     <= dot_d;
      line_q    <= line_d;
      hborder_q <= hborder_d;
      hblank_q  <= hblank_d;
      code_en_q <= code_en_d;
      vborder_q <= vborder_d;
      vblank_q  <= vblank_d;
      char_q    <= char_d;
      shift_q   <= shift_d;
      pal_q     <= pal_d;
      col_q     <= col_d;
      row_q     <= row_d;
    end
  end

endmodule

// ===== hw/rtl/character_video_display_generator.sv =====
// Character video generator, one beat in and one beat out per pixel clock
// while out_o.ready does not stall it. Each beat passes through the input
// register, then the raster state update feeding the result register.
// Throughput: one beat per cycle unless out_o stalls; the input register refills
// as the result drains. Reset (async, active low) clears both stages and
// returns the raster state to the start of a field.
module character_video_display_generator
  import cvdg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  cvdg_in_if.sink     in_i,
  cvdg_out_if.source  out_o
);

  logic     in_valid_q;
  in_item_t in_q;
  logic     out_valid_q;
  result_t  out_q;
  result_t  res;
  logic     advance;

  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_q.func      <= in_i.func;
      in_q.pal_value <= in_i.pal_value;
      in_q.rom_byte  <= in_i.rom_byte;
      in_q.ram_byte  <= in_i.ram_byte;
    end
  end

  cvdg_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) out_q <= res;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.pixel_write = out_q.pixel_write;
  assign out_o.pixel_x     = out_q.pixel_x;
  assign out_o.pixel_y     = out_q.pixel_y;
  assign out_o.pixel_rgb   = out_q.pixel_rgb;
  assign out_o.line_number = out_q.line_number;
  assign out_o.hblank_flag = out_q.hblank_flag;
  assign out_o.vblank_flag = out_q.vblank_flag;
  assign out_o.irq_pulse   = out_q.irq_pulse;
  assign out_o.field_end   = out_q.field_end;
  assign out_o.rom_addr    = out_q.rom_addr;
  assign out_o.ram_addr    = out_q.ram_addr;

`ifndef SYNTHESIS
  a_irq_in_vblank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.irq_pulse |-> out_q.vblank_flag)
    else $error("irq pulse without vblank");

  a_field_end_line0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.field_end |-> out_q.line_number == 9'd0 && !out_q.irq_pulse)
    else $error("field end with nonzero line");

  a_pixel_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.pixel_write |->
      out_q.pixel_x < FbCols && out_q.pixel_y >= VTop)
    else $error("pixel outside framebuffer");

  a_empty_takes_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with empty result register");
`endif

endmodule

// ===== dv/cvdg_raster_checker.sv =====
`timescale 1ns / 1ps

module cvdg_raster_checker
  import cvdg_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  cvdg_in_if   in_mon,
  cvdg_out_if  out_mon,
  output int   errors_o,
  output int   pending_o
);

  // Raster timing, in dots within a line and lines within a field.
  localparam logic [8:0] PalEnDot      = 9'd4;
  localparam logic [8:0] BorderOffDot  = 9'd8;
  localparam logic [8:0] BorderOnDot   = 9'(8 + VISIBLE_WIDTH);
  localparam logic [8:0] BlankOnDot    = 9'(8 + VISIBLE_WIDTH + 64);
  localparam logic [8:0] BlankOffDot   = 9'(8 + VISIBLE_WIDTH + 144);
  localparam logic [8:0] LastDot       = 9'(8 + VISIBLE_WIDTH + 191);
  localparam logic [8:0] BorderLine    = 9'(VISIBLE_LINES);
  localparam logic [8:0] IrqLine       = 9'(VISIBLE_LINES + 25);
  localparam logic [8:0] VblankEndLine = 9'(VISIBLE_LINES + 45);
  localparam logic [8:0] WrapLine      = 9'(VISIBLE_LINES + 70);
  localparam logic [8:0] ColLimit      = 9'(VISIBLE_WIDTH + 112);
  localparam logic [8:0] RowLimit      = 9'(VISIBLE_LINES + 50);
  localparam logic [8:0] TopRow        = 9'd25;
  localparam logic [10:0] TextBase     = 11'h200;
  localparam logic [3:0] FgCode        = 4'h8;
  localparam logic [3:0] BgCode        = 4'h9;
  localparam logic [7:0] LinePalette   = 8'h0F;

  localparam logic [23:0] RGB_LUT [16] = '{
    24'h000000, 24'h3800ff, 24'hff00b0, 24'hff9632,
    24'hffff20, 24'h47ff8b, 24'h00e0ff, 24'h6900ff,
    24'h7f7f7f, 24'h64249f, 24'h9c2582, 24'hb97b62,
    24'ha0d55e, 24'h67de79, 24'h00bae9, 24'hffffff
  };

  typedef struct packed {
    logic [8:0] dot;
    logic [8:0] line;
    logic       hborder;
    logic       hblank;
    logic       code_en;
    logic       vborder;
    logic       vblank;
    logic [7:0] chr;
    logic [7:0] shifter;
    logic [7:0] pal;
    logic [8:0] col;
    logic [8:0] row;
  } raster_t;

  raster_t  rs;
  result_t  expected_q [$];
  result_t  want;
  in_item_t beat;
  int       mismatches = 0;

  assign errors_o  = mismatches;
  assign pending_o = expected_q.size();

  function automatic result_t advance_raster(input in_item_t b);
    result_t    r;
    logic [2:0] phase;
    logic [3:0] idx;
    r = '0;
    if (b.func == FUNC_PAL_WRITE) begin
      rs.pal = b.pal_value;
    end else begin
      phase = rs.dot[2:0];
      if (!rs.hborder && !rs.vborder && rs.row < RowLimit && rs.col < ColLimit) begin
        idx           = rs.shifter[7] ? rs.pal[3:0] : rs.pal[7:4];
        r.pixel_write = 1'b1;
        r.pixel_x     = rs.col;
        r.pixel_y     = 9'(rs.row + TopRow);
        r.pixel_rgb   = RGB_LUT[idx];
      end
      rs.col     = rs.col + 9'd1;
      rs.shifter = (phase == 3'd0) ? b.rom_byte : {rs.shifter[6:0], 1'b0};
      // control codes latched last cell take effect on the cell boundary
      if (rs.code_en && phase == 3'd0) begin
        if (rs.chr[7:4] == FgCode) rs.pal[3:0] = rs.chr[3:0];
        if (rs.chr[7:4] == BgCode) rs.pal[7:4] = rs.chr[3:0];
      end
      if (phase == 3'd4) rs.chr = b.ram_byte;
      if (rs.dot == PalEnDot) rs.code_en = 1'b1;
      if (rs.dot == BorderOffDot) rs.hborder = 1'b0;
      if (rs.dot == BorderOnDot) begin
        rs.hborder = 1'b1;
        rs.code_en = 1'b0;
        rs.pal     = LinePalette;
      end
      if (rs.dot == BlankOnDot) rs.hblank = 1'b1;
      if (rs.dot == BlankOffDot) begin
        rs.hblank = 1'b0;
        rs.row    = rs.row + 9'd1;
        rs.col    = '0;
      end
      if (rs.dot == LastDot) begin
        rs.dot  = '0;
        rs.line = rs.line + 9'd1;
        if (rs.line == BorderLine) rs.vborder = 1'b1;
        if (rs.line == IrqLine) begin
          rs.vblank   = 1'b1;
          r.irq_pulse = 1'b1;
        end
        if (rs.line == VblankEndLine) rs.vblank = 1'b0;
        if (rs.line == WrapLine) begin
          rs.line     = '0;
          rs.vborder  = 1'b0;
          rs.row      = '0;
          r.field_end = 1'b1;
        end
      end else begin
        rs.dot = rs.dot + 9'd1;
      end
    end
    r.line_number = rs.line;
    r.hblank_flag = rs.hblank;
    r.vblank_flag = rs.vblank;
    r.rom_addr    = {rs.chr, rs.line[2:0]};
    r.ram_addr    = TextBase + {1'b0, rs.line[7:3], rs.dot[7:3]};
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [23:0] exp_v,
                                      input logic [23:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs = '{dot: '0, line: '0, hborder: 1'b1, hblank: 1'b0, code_en: 1'b0,
             vborder: 1'b0, vblank: 1'b0, chr: 8'h12, shifter: 8'hF3,
             pal: 8'h0F, col: 9'd47, row: '0};
      expected_q.delete();
    end else begin
      // results leave only after their beat has passed the input and result registers, so check before queuing
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected");
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          check_field("pixel_write", 24'(want.pixel_write), 24'(out_mon.pixel_write));
          check_field("pixel_x",     24'(want.pixel_x),     24'(out_mon.pixel_x));
          check_field("pixel_y",     24'(want.pixel_y),     24'(out_mon.pixel_y));
          check_field("pixel_rgb",   want.pixel_rgb,        out_mon.pixel_rgb);
          check_field("line_number", 24'(want.line_number), 24'(out_mon.line_number));
          check_field("hblank_flag", 24'(want.hblank_flag), 24'(out_mon.hblank_flag));
          check_field("vblank_flag", 24'(want.vblank_flag), 24'(out_mon.vblank_flag));
          check_field("irq_pulse",   24'(want.irq_pulse),   24'(out_mon.irq_pulse));
          check_field("field_end",   24'(want.field_end),   24'(out_mon.field_end));
          check_field("rom_addr",    24'(want.rom_addr),    24'(out_mon.rom_addr));
          check_field("ram_addr",    24'(want.ram_addr),    24'(out_mon.ram_addr));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        beat = '{func: in_mon.func, pal_value: in_mon.pal_value,
                 rom_byte: in_mon.rom_byte, ram_byte: in_mon.ram_byte};
        expected_q.push_back(advance_raster(beat));
      end
    end
  end

endmodule

// ===== dv/character_video_display_generator_tb.sv =====
`timescale 1ns / 1ps

module character_video_display_generator_tb;
  import cvdg_pkg::*;

  localparam int PhaseBeats  = 450;
  localparam int HoldCycles  = 60;
  localparam int DrainCycles = 8;
  localparam int CycleLimit  = 200000;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        hold_go;
  int          tx_idle_pct;
  int          rx_idle_pct;
  int          errors;
  int          pending;
  int unsigned cycles = 0;

  // sender / receiver idle percentages per random phase
  int tx_pct [3] = '{35, 59, 0};
  int rx_pct [3] = '{59, 35, 0};

  // walks the first cell boundaries: border release, fg and bg codes, CPU writes
  in_item_t seed_beats [22] = '{
    '{FUNC_PAL_WRITE, 8'h00, 8'h00, 8'h00},
    '{FUNC_TICK,      8'hFF, 8'hFF, 8'h00},
    '{FUNC_TICK,      8'h00, 8'h00, 8'hFF},
    '{FUNC_PAL_WRITE, 8'hFF, 8'hFF, 8'hFF},
    '{FUNC_TICK,      8'h55, 8'hFF, 8'h80},
    '{FUNC_TICK,      8'hAA, 8'h00, 8'h9F},
    '{FUNC_TICK,      8'h0F, 8'h5A, 8'h8F},
    '{FUNC_TICK,      8'hF0, 8'hA5, 8'h90},
    '{FUNC_TICK,      8'h00, 8'hFF, 8'h00},
    '{FUNC_TICK,      8'hFF, 8'h00, 8'hFF},
    '{FUNC_TICK,      8'h3C, 8'h81, 8'h00},
    '{FUNC_TICK,      8'hC3, 8'h00, 8'h00},
    '{FUNC_PAL_WRITE, 8'hA5, 8'h00, 8'h00},
    '{FUNC_TICK,      8'h00, 8'h7E, 8'h11},
    '{FUNC_TICK,      8'h00, 8'hFF, 8'h22},
    '{FUNC_TICK,      8'h00, 8'h00, 8'h9A},
    '{FUNC_TICK,      8'h00, 8'hFF, 8'h33},
    '{FUNC_TICK,      8'h00, 8'h00, 8'h44},
    '{FUNC_TICK,      8'h00, 8'hFF, 8'h55},
    '{FUNC_TICK,      8'h00, 8'h0F, 8'h66},
    '{FUNC_TICK,      8'h00, 8'hF0, 8'h77},
    '{FUNC_TICK,      8'h00, 8'h00, 8'h88}
  };

  cvdg_in_if  in_bus ();
  cvdg_out_if out_bus ();

  character_video_display_generator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  cvdg_raster_checker u_raster_chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon    (in_bus),
    .out_mon   (out_bus),
    .errors_o  (errors),
    .pending_o (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("character_video_display_generator_tb: errors");
      $finish;
    end
  end

  // result side: random backpressure plus one long hold-off
  initial begin
    int hold_cnt;
    hold_cnt      = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_go && hold_cnt < HoldCycles) begin
        out_bus.ready <= 1'b0;
        hold_cnt++;
      end else begin
        out_bus.ready <= rst_ni && ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic push_beat(input in_item_t b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid     <= 1'b1;
    in_bus.func      <= b.func;
    in_bus.pal_value <= b.pal_value;
    in_bus.rom_byte  <= b.rom_byte;
    in_bus.ram_byte  <= b.ram_byte;
    do @(posedge clk_i); while (!in_bus.ready);
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    in_item_t b;
    int       pick;
    in_bus.valid     = 1'b0;
    in_bus.func      = FUNC_TICK;
    in_bus.pal_value = '0;
    in_bus.rom_byte  = '0;
    in_bus.ram_byte  = '0;
    hold_go          = 1'b0;
    tx_idle_pct      = 0;
    rx_idle_pct      = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (seed_beats[i]) push_beat(seed_beats[i]);
    wait_drained();

    for (int p = 0; p < 3; p++) begin
      tx_idle_pct = tx_pct[p];
      rx_idle_pct = rx_pct[p];
      // last phase: sender streams while the receiver stalls, filling the block
      if (p == 2) hold_go = 1'b1;
      repeat (PhaseBeats) begin
        b.func      = ($urandom_range(99) < 8) ? FUNC_PAL_WRITE : FUNC_TICK;
        b.pal_value = 8'($urandom_range(255));
        b.rom_byte  = 8'($urandom);
        pick        = $urandom_range(9);
        if (pick < 3)
          b.ram_byte = {CodeFg, 4'($urandom_range(15))};
        else if (pick < 5)
          b.ram_byte = {CodeBg, 4'($urandom_range(15))};
        else
          b.ram_byte = 8'($urandom);
        push_beat(b);
      end
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("character_video_display_generator_tb: clean");
    end else begin
      $display("character_video_display_generator_tb: errors");
    end
    $finish;
  end

endmodule
